// File: sv/mclif_pkg.sv
// ----------------------------------------------------------------------------
// mclif_pkg
// Shared types and constants of the four-compartment integrate-and-fire step.
// ----------------------------------------------------------------------------
`default_nettype none

package mclif_pkg;

   localparam int DECAY_FRACTION_ENTRIES = 256;
   localparam int QUEUE_DEPTH = 8;

   localparam int NUM_COMP = 4;
   localparam int CUR_W = 24;
   localparam int MEMBRANE_W = 26;
   localparam int THRESHOLD_W = 25;
   localparam int TICK_W = 32;
   localparam int WEIGHT_W = 16;
   localparam int FACTOR_W = 17;
   localparam int SHIFT_W = 5;
   localparam int RATE_W = 15;
   localparam int GAIN_W = 13;
   localparam int DATA_W = 32;
   localparam int ADDR_W = 3;

   typedef enum logic [1:0] {
      RECEPTOR_AMPA   = 2'd0,
      RECEPTOR_NMDA   = 2'd1,
      RECEPTOR_GABA_A = 2'd2,
      RECEPTOR_GABA_B = 2'd3
   } receptor_type;

   // register index, taken from paddr[2]
   localparam logic REG_THRESHOLD = 1'b0;

   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 25'd4096;

   // log2(e)/tau in Q16, by receptor
   localparam logic [RATE_W-1:0] DECAY_RATE [NUM_COMP] = '{
      15'd18910, 15'd945, 15'd9455, 15'd630
   };

   // receptor gain in Q12
   localparam logic [GAIN_W-1:0] GAIN [NUM_COMP] = '{
      13'd4096, 13'd2253, 13'd4096, 13'd2662
   };

   localparam receptor_type TC_RESET [NUM_COMP] = '{
      RECEPTOR_AMPA, RECEPTOR_AMPA, RECEPTOR_NMDA, RECEPTOR_GABA_A
   };

   localparam logic [63:0] LN2_Q30 = 64'd744261118;
   localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
   localparam logic [SHIFT_W-1:0] KILL_SHIFT = 5'd24;

   // one classified event, decay terms worked out for every receptor kind
   typedef struct packed {
      logic [1:0]                          target;
      receptor_type                        receptor;
      logic signed [CUR_W-1:0]             applied;
      logic                                keep;
      logic [NUM_COMP-1:0]                 kill;
      logic [NUM_COMP-1:0][SHIFT_W-1:0]    shift;
      logic [NUM_COMP-1:0][FACTOR_W-1:0]   factor;
   } decay_item_type;

   typedef struct packed {
      logic valid;
      logic take;
   } queue_ctrl_type;

endpackage

`default_nettype wire

// File: sv/mclif_front.sv
// ----------------------------------------------------------------------------
// mclif_front
// Two-stage front end: elapsed time, decay shift and fraction for each
// receptor kind, and the signed gained weight.
// ----------------------------------------------------------------------------
`default_nettype none

module mclif_front #(
   parameter int ENTRIES = mclif_pkg::DECAY_FRACTION_ENTRIES
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  in_valid,
   input  wire logic [1:0]                            in_target,
   input  wire logic [1:0]                            in_receptor,
   input  wire logic [mclif_pkg::WEIGHT_W-1:0]        in_weight,
   input  wire logic [mclif_pkg::TICK_W-1:0]          in_tick,
   output logic                                       out_valid,
   output mclif_pkg::decay_item_type                  out_item
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int SCALE_W = 16 + $clog2(ENTRIES + 1);
   localparam int PROD_W = mclif_pkg::TICK_W + mclif_pkg::RATE_W;
   localparam int GPROD_W = mclif_pkg::WEIGHT_W + mclif_pkg::GAIN_W;
   localparam int MAG_W = GPROD_W - 12;

   typedef logic [mclif_pkg::FACTOR_W-1:0] frac_table_type [ENTRIES];

   // 2^-(idx/N) in Q16 by a series of exp(-x) through the tenth-power term
   function automatic frac_table_type build_frac_table();
      frac_table_type t;
      logic [63:0]    x;
      logic [63:0]    sum;
      logic [63:0]    term;
      for (int i = 0; i < ENTRIES; i++) begin
         x = (64'(i) * mclif_pkg::LN2_Q30) / 64'(ENTRIES);
         sum = mclif_pkg::ONE_Q30;
         term = mclif_pkg::ONE_Q30;
         for (int n = 1; n <= 10; n++) begin
            term = ((term * x) >> 30) / 64'(n);
            if (n % 2 == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         t[i] = mclif_pkg::FACTOR_W'((sum + (64'd1 << 13)) >> 14);
      end
      return t;
   endfunction

   localparam frac_table_type FRAC_TABLE = build_frac_table();

   logic [mclif_pkg::TICK_W-1:0]     last_tick_ff;

   logic                             s1_valid_ff;
   logic [1:0]                       s1_target_ff;
   mclif_pkg::receptor_type          s1_receptor_ff;
   logic [mclif_pkg::WEIGHT_W-1:0]   s1_weight_ff;
   logic [mclif_pkg::TICK_W-1:0]     s1_elapsed_ff;
   logic                             s1_keep_ff;
   logic [mclif_pkg::TICK_W-1:0]     s1_elapsed_in;
   logic                             s1_keep_in;

   logic                                                    s2_valid_ff;
   logic [1:0]                                              s2_target_ff;
   mclif_pkg::receptor_type                                 s2_receptor_ff;
   logic signed [mclif_pkg::CUR_W-1:0]                      s2_applied_ff;
   logic                                                    s2_keep_ff;
   logic [mclif_pkg::NUM_COMP-1:0]                          s2_kill_ff;
   logic [mclif_pkg::NUM_COMP-1:0][mclif_pkg::SHIFT_W-1:0]  s2_shift_ff;
   logic [mclif_pkg::NUM_COMP-1:0][IDX_W-1:0]               s2_idx_ff;

   logic signed [mclif_pkg::CUR_W-1:0]                      s2_applied_in;
   logic [mclif_pkg::NUM_COMP-1:0]                          s2_kill_in;
   logic [mclif_pkg::NUM_COMP-1:0][mclif_pkg::SHIFT_W-1:0]  s2_shift_in;
   logic [mclif_pkg::NUM_COMP-1:0][IDX_W-1:0]               s2_idx_in;

   logic [PROD_W-1:0]                rate_prod [mclif_pkg::NUM_COMP];
   logic [SCALE_W-1:0]               frac_scaled [mclif_pkg::NUM_COMP];
   logic [GPROD_W-1:0]               gain_prod;
   logic [mclif_pkg::CUR_W-1:0]      gain_mag;

   // every compartment shares one last tick: each event moves all of them
   always_comb begin
      s1_elapsed_in = in_tick - last_tick_ff;
      s1_keep_in = !(in_tick > last_tick_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_tick_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         if (in_valid) begin
            last_tick_ff <= in_tick;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         s1_target_ff <= in_target;
         s1_receptor_ff <= mclif_pkg::receptor_type'(in_receptor);
         s1_weight_ff <= in_weight;
         s1_elapsed_ff <= s1_elapsed_in;
         s1_keep_ff <= s1_keep_in;
      end
   end

   always_comb begin
      for (int k = 0; k < mclif_pkg::NUM_COMP; k++) begin
         rate_prod[k] = PROD_W'(s1_elapsed_ff) * PROD_W'(mclif_pkg::DECAY_RATE[k]);
         s2_shift_in[k] = rate_prod[k][16 +: mclif_pkg::SHIFT_W];
         s2_kill_in[k] = (|rate_prod[k][PROD_W-1:16+mclif_pkg::SHIFT_W]) ||
                         (s2_shift_in[k] >= mclif_pkg::KILL_SHIFT);
         frac_scaled[k] = SCALE_W'(rate_prod[k][15:0]) * SCALE_W'(ENTRIES);
         s2_idx_in[k] = frac_scaled[k][16 +: IDX_W];
      end
      gain_prod = GPROD_W'(s1_weight_ff) * GPROD_W'(mclif_pkg::GAIN[s1_receptor_ff])
                + GPROD_W'(2048);
      gain_mag = mclif_pkg::CUR_W'(gain_prod[GPROD_W-1:12]);
      // inhibitory receptors subtract
      if (s1_receptor_ff == mclif_pkg::RECEPTOR_GABA_A ||
          s1_receptor_ff == mclif_pkg::RECEPTOR_GABA_B) begin
         s2_applied_in = -$signed(gain_mag);
      end else begin
         s2_applied_in = $signed(gain_mag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_target_ff <= s1_target_ff;
         s2_receptor_ff <= s1_receptor_ff;
         s2_applied_ff <= s2_applied_in;
         s2_keep_ff <= s1_keep_ff;
         s2_kill_ff <= s2_kill_in;
         s2_shift_ff <= s2_shift_in;
         s2_idx_ff <= s2_idx_in;
      end
   end

   always_comb begin
      out_valid = s2_valid_ff;
      out_item.target = s2_target_ff;
      out_item.receptor = s2_receptor_ff;
      out_item.applied = s2_applied_ff;
      out_item.keep = s2_keep_ff;
      out_item.kill = s2_kill_ff;
      out_item.shift = s2_shift_ff;
      for (int k = 0; k < mclif_pkg::NUM_COMP; k++) begin
         out_item.factor[k] = FRAC_TABLE[s2_idx_ff[k]];
      end
   end

   // keep MAG_W tied to the gain product layout
   if (MAG_W > mclif_pkg::CUR_W) begin : g_mag_check
      $error("gain magnitude wider than current");
   end

endmodule

`default_nettype wire

// File: sv/mclif_queue.sv
// ----------------------------------------------------------------------------
// mclif_queue
// Small register queue between the front end and the compartment update.
// ----------------------------------------------------------------------------
`default_nettype none

module mclif_queue #(
   parameter int DEPTH = mclif_pkg::QUEUE_DEPTH
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        wr_valid,
   input  wire mclif_pkg::decay_item_type   wr_item,
   output mclif_pkg::queue_ctrl_type        head_ctrl_out,
   input  wire logic                        head_take,
   output mclif_pkg::decay_item_type        head_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mclif_pkg::decay_item_type   mem_ff [DEPTH];
   logic [PTR_W-1:0]            wr_ptr_ff;
   logic [PTR_W-1:0]            rd_ptr_ff;
   logic [CNT_W-1:0]            count_ff;
   logic                        take;

   assign take = head_take && (count_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (wr_valid) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (take) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (wr_valid && !take) begin
            count_ff <= count_ff + 1'b1;
         end else if (!wr_valid && take) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_valid) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

   always_comb begin
      head_ctrl_out.valid = (count_ff != '0);
      head_ctrl_out.take = take;
      head_item = mem_ff[rd_ptr_ff];
   end

endmodule

`default_nettype wire

// File: sv/mclif_back.sv
// ----------------------------------------------------------------------------
// mclif_back
// Compartment state: decay, weighted add, membrane sum, firing and reset,
// one event per cycle into the result register while it is empty or being popped.
// ----------------------------------------------------------------------------
`default_nettype none

module mclif_back (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    item_valid,
   input  wire mclif_pkg::decay_item_type               item,
   output logic                                         item_take,
   input  wire logic [mclif_pkg::THRESHOLD_W-1:0]       threshold,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_take,
   output logic signed [mclif_pkg::CUR_W-1:0]           rsp_applied,
   output logic signed [mclif_pkg::MEMBRANE_W-1:0]      rsp_membrane,
   output logic                                         rsp_fired
);

   localparam int CUR_W = mclif_pkg::CUR_W;
   localparam int MPROD_W = CUR_W + mclif_pkg::FACTOR_W;
   localparam int NC = mclif_pkg::NUM_COMP;

   logic signed [CUR_W-1:0]           cur_ff [NC];
   mclif_pkg::receptor_type           tc_ff [NC];
   logic                              out_valid_ff;
   logic signed [CUR_W-1:0]           out_applied_ff;
   logic signed [mclif_pkg::MEMBRANE_W-1:0] out_membrane_ff;
   logic                              out_fired_ff;

   logic signed [CUR_W-1:0]           cur_in [NC];
   logic signed [CUR_W-1:0]           decayed [NC];
   logic [CUR_W-1:0]                  mag [NC];
   logic [MPROD_W-1:0]                mprod [NC];
   logic [MPROD_W-17:0]               rounded [NC];
   logic [MPROD_W-17:0]               shifted [NC];
   logic [1:0]                        kind [NC];
   logic signed [CUR_W:0]             target_sum;
   logic signed [CUR_W-1:0]           target_new;
   logic signed [mclif_pkg::MEMBRANE_W-1:0] membrane;
   logic                              fire;
   logic                              advance;

   assign advance = item_valid && (!out_valid_ff || rsp_take);
   assign item_take = advance;

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         kind[c] = tc_ff[c];
         mag[c] = cur_ff[c][CUR_W-1] ? CUR_W'(-cur_ff[c]) : CUR_W'(cur_ff[c]);
         mprod[c] = MPROD_W'(mag[c]) * MPROD_W'(item.factor[kind[c]])
                  + MPROD_W'(32'h8000);
         rounded[c] = mprod[c][MPROD_W-1:16];
         shifted[c] = rounded[c] >> item.shift[kind[c]];
         if (item.keep) begin
            decayed[c] = cur_ff[c];
         end else if (item.kill[kind[c]]) begin
            decayed[c] = '0;
         end else if (cur_ff[c][CUR_W-1]) begin
            decayed[c] = -$signed(shifted[c][CUR_W-1:0]);
         end else begin
            decayed[c] = $signed(shifted[c][CUR_W-1:0]);
         end
      end

      target_sum = {decayed[item.target][CUR_W-1], decayed[item.target]}
                 + {item.applied[CUR_W-1], item.applied};
      // saturate to the current range
      if (target_sum[CUR_W] != target_sum[CUR_W-1]) begin
         target_new = target_sum[CUR_W] ? {1'b1, {(CUR_W-1){1'b0}}}
                                        : {1'b0, {(CUR_W-1){1'b1}}};
      end else begin
         target_new = target_sum[CUR_W-1:0];
      end

      membrane = '0;
      for (int c = 0; c < NC; c++) begin
         cur_in[c] = (c == int'(item.target)) ? target_new : decayed[c];
         membrane = membrane + mclif_pkg::MEMBRANE_W'(cur_in[c]);
      end
      fire = $signed({membrane[mclif_pkg::MEMBRANE_W-1], membrane}) >=
             $signed({2'b00, threshold});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         for (int c = 0; c < NC; c++) begin
            cur_ff[c] <= '0;
            tc_ff[c] <= mclif_pkg::TC_RESET[c];
         end
      end else begin
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            out_valid_ff <= 1'b0;
         end
         if (advance) begin
            for (int c = 0; c < NC; c++) begin
               if (fire) begin
                  cur_ff[c] <= '0;
                  tc_ff[c] <= mclif_pkg::TC_RESET[c];
               end else begin
                  cur_ff[c] <= cur_in[c];
                  if (c == int'(item.target)) begin
                     tc_ff[c] <= item.receptor;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_applied_ff <= item.applied;
         out_membrane_ff <= fire ? '0 : membrane;
         out_fired_ff <= fire;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_applied = out_applied_ff;
   assign rsp_membrane = out_membrane_ff;
   assign rsp_fired = out_fired_ff;

endmodule

`default_nettype wire

// File: sv/multi_compartment_lif_neuron_step_unit.sv
// ----------------------------------------------------------------------------
// multi_compartment_lif_neuron_step_unit
// Four-compartment leaky integrate-and-fire neuron, one input event a step.
// ----------------------------------------------------------------------------
// path: an accepted event passes front stages s1 and s2, the queue and the back end's result register
// throughput: one event per cycle while full is low and results are popped; the compartment update
//   loop in the back end is combinational between cur_ff registers, the front end runs two stages ahead of it
// full rises when front stages plus queue hold QUEUE_DEPTH events
// reset: currents and ticks cleared, time constants AMPA, AMPA, NMDA, GABA_A,
//   threshold 1.0 in Q12
`default_nettype none

module multi_compartment_lif_neuron_step_unit #(
   parameter int DECAY_FRACTION_ENTRIES = mclif_pkg::DECAY_FRACTION_ENTRIES,
   parameter int QUEUE_DEPTH = mclif_pkg::QUEUE_DEPTH
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,

   input  wire logic                                     push,
   output logic                                          full,
   input  wire logic [1:0]                               req_target_compartment,
   input  wire logic [1:0]                               req_receptor_kind,
   input  wire logic [mclif_pkg::WEIGHT_W-1:0]           req_synaptic_weight,
   input  wire logic [mclif_pkg::TICK_W-1:0]             req_event_tick,

   output logic                                          empty,
   input  wire logic                                     pop,
   output logic signed [mclif_pkg::CUR_W-1:0]            rsp_input_current,
   output logic signed [mclif_pkg::MEMBRANE_W-1:0]       rsp_membrane_level,
   output logic                                          rsp_fired,

   input  wire logic                                     psel,
   input  wire logic                                     penable,
   input  wire logic                                     pwrite,
   input  wire logic [mclif_pkg::ADDR_W-1:0]             paddr,
   input  wire logic [mclif_pkg::DATA_W-1:0]             pwdata,
   output logic [mclif_pkg::DATA_W-1:0]                  prdata,
   output logic                                          pready
);

   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

   logic [mclif_pkg::THRESHOLD_W-1:0]   threshold_ff;
   logic [OCC_W-1:0]                    occ_ff;
   logic                                accept;
   logic                                csr_write;

   logic                                front_valid;
   mclif_pkg::decay_item_type           front_item;
   mclif_pkg::queue_ctrl_type           queue_ctrl;
   mclif_pkg::decay_item_type           head_item;
   logic                                back_take;
   logic                                rsp_valid;

   assign accept = push && !full;
   assign full = (occ_ff == OCC_W'(QUEUE_DEPTH));
   assign empty = !rsp_valid;

   // config port
   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == mclif_pkg::REG_THRESHOLD);
   assign prdata = (paddr[2] == mclif_pkg::REG_THRESHOLD) ?
                   mclif_pkg::DATA_W'(threshold_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= mclif_pkg::THRESHOLD_RESET;
      end else if (csr_write) begin
         threshold_ff <= pwdata[mclif_pkg::THRESHOLD_W-1:0];
      end
   end

   // events in flight in the front stages or waiting in the queue
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else if (accept && !queue_ctrl.take) begin
         occ_ff <= occ_ff + 1'b1;
      end else if (!accept && queue_ctrl.take) begin
         occ_ff <= occ_ff - 1'b1;
      end
   end

   mclif_front #(
      .ENTRIES (DECAY_FRACTION_ENTRIES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (accept),
      .in_target   (req_target_compartment),
      .in_receptor (req_receptor_kind),
      .in_weight   (req_synaptic_weight),
      .in_tick     (req_event_tick),
      .out_valid   (front_valid),
      .out_item    (front_item)
   );

   mclif_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock         (clock),
      .reset         (reset),
      .wr_valid      (front_valid),
      .wr_item       (front_item),
      .head_ctrl_out (queue_ctrl),
      .head_take     (back_take),
      .head_item     (head_item)
   );

   mclif_back u_back (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (queue_ctrl.valid),
      .item         (head_item),
      .item_take    (back_take),
      .threshold    (threshold_ff),
      .rsp_valid    (rsp_valid),
      .rsp_take     (pop),
      .rsp_applied  (rsp_input_current),
      .rsp_membrane (rsp_membrane_level),
      .rsp_fired    (rsp_fired)
   );

   a_occ_bound : assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(QUEUE_DEPTH))
      else $error("event count exceeds queue depth");

   a_fired_zero : assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_fired) |-> (rsp_membrane_level == '0))
      else $error("fired result with nonzero membrane potential");

   a_occ_step : assert property (@(posedge clock) disable iff (reset)
      (accept && !queue_ctrl.take) |=> (occ_ff == $past(occ_ff) + 1'b1))
      else $error("event count did not follow an accepted event");

   a_take_valid : assert property (@(posedge clock) disable iff (reset)
      back_take |-> queue_ctrl.valid)
      else $error("back end took from an empty queue");

endmodule

`default_nettype wire
